>>> rtl/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// Shared constants and types of the packet block averager.
// ----------------------------------------------------------------------------
package pba_pkg;

	localparam int MAX_BLOCK_DEF   = 256;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int REG_BITS        = 9;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [REG_BITS-1:0] BLOCK_LEN_RST = REG_BITS'(4);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_DONE = 3'b100
	} pba_state_t;

endpackage

>>> rtl/pba_if.sv
// ----------------------------------------------------------------------------
// pba_if
// Channel interfaces of the packet block averager: samples, averages, config.
// ----------------------------------------------------------------------------
interface pba_in_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          packet_end;

	modport source (output valid, output sample, output packet_end, input ready);
	modport sink   (input valid, input sample, input packet_end, output ready);
endinterface

interface pba_out_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] average;
	logic                          last_of_packet;

	modport source (output valid, output average, output last_of_packet, input ready);
	modport sink   (input valid, input average, input last_of_packet, output ready);
endinterface

interface pba_cfg_if #(parameter int DATA_BITS = 9);
	logic                 valid;
	logic                 ready;
	logic [DATA_BITS-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/pba_front.sv
// ----------------------------------------------------------------------------
// pba_front
// Accumulates samples, holds block_len, and pushes one closed block
// (sum, count, packet end) per average into the queue.
// ----------------------------------------------------------------------------
module pba_front
	import pba_pkg::*;
#(
	parameter int MAX_BLOCK   = MAX_BLOCK_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int CNT_W      = $clog2(MAX_BLOCK + 1),
	localparam int SUM_W      = SAMPLE_BITS + $clog2(MAX_BLOCK),
	localparam int ENTRY_W    = SUM_W + CNT_W + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	pba_in_if.sink             samples,
	pba_cfg_if.sink            cfg,
	output logic               push_valid,
	input  logic               push_ready,
	output logic [ENTRY_W-1:0] push_data
);

	localparam int LEN_W = (REG_BITS > CNT_W) ? REG_BITS : CNT_W;

	logic [REG_BITS-1:0]    block_len_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]       count_q;

	logic [LEN_W-1:0]        len_ext;
	logic [LEN_W-1:0]        eff_len;
	logic [CNT_W-1:0]        cnt_next;
	logic signed [SUM_W-1:0] sum_next;
	logic                    last;
	logic                    close;
	logic                    accept;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_len_q <= BLOCK_LEN_RST;
		end else if (cfg.valid) begin
			block_len_q <= cfg.data;
		end
	end

	// zero acts as one, oversize clamps to the accumulator's capacity
	always_comb begin
		len_ext = LEN_W'(block_len_q);
		if (len_ext == '0) begin
			eff_len = LEN_W'(1);
		end else if (len_ext > LEN_W'(MAX_BLOCK)) begin
			eff_len = LEN_W'(MAX_BLOCK);
		end else begin
			eff_len = len_ext;
		end
	end

	assign last     = samples.packet_end;
	assign cnt_next = count_q + CNT_W'(1);
	assign sum_next = sum_q + {{(SUM_W - SAMPLE_BITS){samples.sample[SAMPLE_BITS-1]}},
		samples.sample};
	assign close    = last || (LEN_W'(cnt_next) >= eff_len);

	assign samples.ready = push_ready;
	assign accept        = samples.valid && samples.ready;
	assign push_valid    = accept && close;
	assign push_data     = {last, cnt_next, sum_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (close) begin
				sum_q   <= '0;
				count_q <= '0;
			end else begin
				sum_q   <= sum_next;
				count_q <= cnt_next;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		LEN_W'(count_q) < LEN_W'(MAX_BLOCK))
		else $error("open block count reached capacity");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> (cnt_next != '0))
		else $error("closed block with zero samples");

	a_clear_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |=> (count_q == '0 && sum_q == '0))
		else $error("accumulator not cleared after close");

endmodule

>>> rtl/pba_queue.sv
// ----------------------------------------------------------------------------
// pba_queue
// Small register queue between the accumulator and the divider.
// ----------------------------------------------------------------------------
module pba_queue
	import pba_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (fill_q != CNT_W'(DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_data   = store_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("queue overfilled");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with pointers apart");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (fill_q == $past(fill_q) + CNT_W'(1)))
		else $error("push lost");

endmodule

>>> rtl/pba_back.sv
// ----------------------------------------------------------------------------
// pba_back
// Bit-serial signed division of a block sum by its count, with an output
// register toward the result channel.
// ----------------------------------------------------------------------------
module pba_back
	import pba_pkg::*;
#(
	parameter int MAX_BLOCK   = MAX_BLOCK_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int CNT_W      = $clog2(MAX_BLOCK + 1),
	localparam int SUM_W      = SAMPLE_BITS + $clog2(MAX_BLOCK),
	localparam int ENTRY_W    = SUM_W + CNT_W + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  logic [ENTRY_W-1:0] pop_data,
	pba_out_if.source          averages
);

	localparam int STEP_W = $clog2(SUM_W);

	pba_state_t state_q;

	logic [SUM_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [STEP_W-1:0] step_q;
	logic              neg_q;
	logic              last_q;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_avg_q;
	logic                          out_last_q;

	logic signed [SUM_W-1:0] in_sum;
	logic [CNT_W-1:0]        in_cnt;
	logic                    in_last;
	logic [SUM_W-1:0]        in_mag;
	logic [CNT_W:0]          trial;
	logic                    qbit;
	logic [CNT_W:0]          diff;
	logic [SUM_W-1:0]        result;
	logic                    out_free;

	assign in_sum  = pop_data[SUM_W-1:0];
	assign in_cnt  = pop_data[SUM_W+CNT_W-1:SUM_W];
	assign in_last = pop_data[ENTRY_W-1];
	assign in_mag  = in_sum[SUM_W-1] ? SUM_W'(-in_sum) : SUM_W'(in_sum);

	assign trial  = {rem_q, dvd_q[SUM_W-1]};
	assign qbit   = (trial >= {1'b0, dsr_q});
	assign diff   = trial - {1'b0, dsr_q};
	assign result = neg_q ? (~dvd_q + SUM_W'(1)) : dvd_q;

	assign out_free  = !out_valid_q || averages.ready;
	assign pop_ready = (state_q == ST_IDLE);

	assign averages.valid          = out_valid_q;
	assign averages.average        = out_avg_q;
	assign averages.last_of_packet = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						state_q <= ST_DIV;
						step_q  <= STEP_W'(SUM_W - 1);
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// restoring division, one quotient bit per cycle shifted into the dividend
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop_valid) begin
			dvd_q  <= in_mag;
			rem_q  <= '0;
			dsr_q  <= in_cnt;
			neg_q  <= in_sum[SUM_W-1];
			last_q <= in_last;
		end else if (state_q == ST_DIV) begin
			dvd_q <= {dvd_q[SUM_W-2:0], qbit};
			rem_q <= qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (averages.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_avg_q  <= result[SAMPLE_BITS-1:0];
			out_last_q <= last_q;
		end
	end

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (dsr_q != '0))
		else $error("division by zero count");

	a_remainder_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < dsr_q))
		else $error("remainder not below divisor");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> out_valid_q)
		else $error("finished average not presented");

endmodule

>>> rtl/packet_block_averager_unit.sv
// ----------------------------------------------------------------------------
// packet_block_averager_unit
// Integrate-and-dump block averager over packetized signed samples.
// ----------------------------------------------------------------------------
// Each accepted sample is added to a running sum; once block_len samples have
// gathered, or the sample ends its packet, the block's sum and count go into a
// two-entry queue and the accumulator clears. Samples take one cycle each as
// long as the queue has room. A bit-serial restoring divider behind the queue
// turns each block into its average, truncated toward zero, one bit of the
// SUM_W-bit block sum at a time (SUM_W = SAMPLE_BITS + log2(MAX_BLOCK), with
// 16-bit samples and 256-sample blocks by default); that divider sets the
// sustained rate when blocks are short. block_len of 0 behaves as 1 and
// values above MAX_BLOCK behave as MAX_BLOCK. The output register lets the
// next division run while an average waits to be taken.
// ----------------------------------------------------------------------------
module packet_block_averager_unit
	import pba_pkg::*;
#(
	parameter int MAX_BLOCK   = MAX_BLOCK_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pba_in_if.sink    samples,
	pba_out_if.source averages,
	pba_cfg_if.sink   cfg
);

	localparam int CNT_W   = $clog2(MAX_BLOCK + 1);
	localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_BLOCK);
	localparam int ENTRY_W = SUM_W + CNT_W + 1;

	logic               push_valid;
	logic               push_ready;
	logic [ENTRY_W-1:0] push_data;
	logic               pop_valid;
	logic               pop_ready;
	logic [ENTRY_W-1:0] pop_data;

	pba_front #(
		.MAX_BLOCK   (MAX_BLOCK),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	pba_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	pba_back #(
		.MAX_BLOCK   (MAX_BLOCK),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.averages  (averages)
	);

endmodule
